/* rtl/cas_pkg.sv */
// shared types and constants of the complex add/sub, magnitude and angle unit
// no dependencies; used by every other file of the block
package cas_pkg;

   localparam int DATA_W      = 16;
   localparam int SUM_W       = 17;
   localparam int MAG_W       = 16;
   localparam int ANG_W       = 15;
   localparam int GUARD_BITS  = 14;
   localparam int XW          = 34;
   localparam int ZW          = 33;
   localparam int TAB_LEN     = 24;
   localparam int GAIN_W      = 30;
   localparam int MX_W        = 31;
   localparam int PROD_W      = MX_W + GAIN_W;
   localparam int ANG_SHIFT   = 17;

   localparam int CORDIC_STAGES_DEF = 16;

   localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
   localparam logic [MAG_W-1:0] MAG_MAX = 16'd46341;
   localparam logic signed [ANG_W-1:0] HALF_PI = 15'sd12868;

   // atan(2^-i) in units of 2^-30 rad, truncated
   localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
      33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
      33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
      33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
      33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
      33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
      33'sd1023,      33'sd511,       33'sd255,       33'sd127
   };

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SUB   = 2'd1,
      OP_MAG   = 2'd2,
      OP_ANGLE = 2'd3
   } op_type;

   // per-transaction data that rides alongside the cordic vector
   typedef struct packed {
      op_type                  op;
      logic signed [SUM_W-1:0] sum_re;
      logic signed [SUM_W-1:0] sum_im;
      logic                    re_zero;
      logic                    im_pos;
      logic                    im_neg;
   } side_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

endpackage

/* rtl/cas_if.sv */
// valid/ready channel interfaces for request and response transactions
// depends on cas_pkg
interface cas_req_if;
   import cas_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               op;
   logic signed [DATA_W-1:0] a_re;
   logic signed [DATA_W-1:0] a_im;
   logic signed [DATA_W-1:0] b_re;
   logic signed [DATA_W-1:0] b_im;

   modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cas_rsp_if;
   import cas_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] sum_re;
   logic signed [SUM_W-1:0] sum_im;
   logic [MAG_W-1:0]        magnitude;
   logic signed [ANG_W-1:0] angle;

   modport source (output valid, sum_re, sum_im, magnitude, angle, input ready);
   modport sink   (input valid, sum_re, sum_im, magnitude, angle, output ready);
endinterface

/* rtl/cas_prep.sv */
// first pipeline stage: complex add/sub and cordic start vector
// depends on cas_pkg
module cas_prep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [1:0]                        in_op,
   input  logic signed [cas_pkg::DATA_W-1:0] a_re,
   input  logic signed [cas_pkg::DATA_W-1:0] a_im,
   input  logic signed [cas_pkg::DATA_W-1:0] b_re,
   input  logic signed [cas_pkg::DATA_W-1:0] b_im,
   output logic                              out_valid,
   output cas_pkg::side_type                 out_side,
   output cas_pkg::vec_type                  out_vec
);
   import cas_pkg::*;

   logic                     valid_ff;
   side_type                 side_ff, side_in;
   vec_type                  vec_ff, vec_in;
   logic signed [DATA_W:0]   re_ext, im_ext, re_fold, im_fold;

   always_comb begin
      re_ext = {b_re[DATA_W-1], b_re};
      im_ext = {b_im[DATA_W-1], b_im};
      side_in.op = op_type'(in_op);
      if (op_type'(in_op) == OP_SUB) begin
         side_in.sum_re = {a_re[DATA_W-1], a_re} - re_ext;
         side_in.sum_im = {a_im[DATA_W-1], a_im} - im_ext;
      end else begin
         side_in.sum_re = {a_re[DATA_W-1], a_re} + re_ext;
         side_in.sum_im = {a_im[DATA_W-1], a_im} + im_ext;
      end
      side_in.re_zero = (b_re == '0);
      side_in.im_neg  = b_im[DATA_W-1];
      side_in.im_pos  = !b_im[DATA_W-1] && (b_im != '0);
      // fold into the right half plane, atan(im/re) is unchanged
      if (b_re[DATA_W-1]) begin
         re_fold = -re_ext;
         im_fold = -im_ext;
      end else begin
         re_fold = re_ext;
         im_fold = im_ext;
      end
      vec_in.x = {{(XW-DATA_W-1-GUARD_BITS){re_fold[DATA_W]}}, re_fold, {GUARD_BITS{1'b0}}};
      vec_in.y = {{(XW-DATA_W-1-GUARD_BITS){im_fold[DATA_W]}}, im_fold, {GUARD_BITS{1'b0}}};
      vec_in.z = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= side_in;
         vec_ff  <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_vec   = vec_ff;

endmodule

/* rtl/cas_cordic_stage.sv */
// one registered vectoring micro-rotation of the cordic pipeline
// depends on cas_pkg
module cas_cordic_stage #(
   parameter int STAGE_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  cas_pkg::side_type in_side,
   input  cas_pkg::vec_type  in_vec,
   output logic              out_valid,
   output cas_pkg::side_type out_side,
   output cas_pkg::vec_type  out_vec
);
   import cas_pkg::*;

   logic                 valid_ff;
   side_type             side_ff;
   vec_type              vec_ff, vec_in;
   logic signed [XW-1:0] xs, ys;

   always_comb begin
      xs = in_vec.x >>> STAGE_IDX;
      ys = in_vec.y >>> STAGE_IDX;
      // rotate towards y = 0
      if (!in_vec.y[XW-1]) begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + ATAN_TAB[STAGE_IDX];
      end else begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - ATAN_TAB[STAGE_IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= in_side;
         vec_ff  <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_vec   = vec_ff;

endmodule

/* rtl/cas_finish.sv */
// gain correction, angle rounding and the response output register
// depends on cas_pkg
module cas_finish (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  cas_pkg::side_type                in_side,
   input  cas_pkg::vec_type                 in_vec,
   output logic                             out_valid,
   output logic signed [cas_pkg::SUM_W-1:0] sum_re,
   output logic signed [cas_pkg::SUM_W-1:0] sum_im,
   output logic [cas_pkg::MAG_W-1:0]        magnitude,
   output logic signed [cas_pkg::ANG_W-1:0] angle
);
   import cas_pkg::*;

   localparam int QW = ZW + 1 - ANG_SHIFT;

   // multiply stage
   logic                    mvalid_ff;
   side_type                mside_ff;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic signed [ZW:0]      z_rnd;
   logic signed [QW-1:0]    q;

   // output stage
   logic                    valid_ff;
   logic signed [SUM_W-1:0] sum_re_ff, sum_re_in, sum_im_ff, sum_im_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic signed [ANG_W-1:0] angle_ff, angle_in;
   logic [PROD_W:0]         m_rnd;
   logic [PROD_W-GUARD_BITS-GAIN_W:0] m_full;

   always_comb begin
      // x is never negative after the fold
      prod_in = PROD_W'(in_vec.x[MX_W-1:0]) * PROD_W'(INV_GAIN);
      z_rnd   = {in_vec.z[ZW-1], in_vec.z} + (ZW+1)'(1 << (ANG_SHIFT-1));
      q       = z_rnd[ZW:ANG_SHIFT];
      if (q > QW'(HALF_PI)) begin
         ang_in = HALF_PI;
      end else if (q < -QW'(HALF_PI)) begin
         ang_in = -HALF_PI;
      end else begin
         ang_in = q[ANG_W-1:0];
      end
      if (in_side.re_zero) begin
         if (in_side.im_pos) begin
            ang_in = HALF_PI;
         end else if (in_side.im_neg) begin
            ang_in = -HALF_PI;
         end else begin
            ang_in = '0;
         end
      end
   end

   always_comb begin
      m_rnd  = {1'b0, prod_ff} + ((PROD_W+1)'(1) << (GUARD_BITS + GAIN_W - 1));
      m_full = m_rnd[PROD_W:GUARD_BITS+GAIN_W];
      sum_re_in = '0;
      sum_im_in = '0;
      mag_in    = '0;
      angle_in  = '0;
      case (mside_ff.op)
         OP_ADD, OP_SUB: begin
            sum_re_in = mside_ff.sum_re;
            sum_im_in = mside_ff.sum_im;
         end
         OP_MAG: begin
            if (m_full > ($bits(m_full))'(MAG_MAX)) begin
               mag_in = MAG_MAX;
            end else begin
               mag_in = m_full[MAG_W-1:0];
            end
         end
         OP_ANGLE: begin
            angle_in = ang_ff;
         end
         default: begin
            mag_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else if (adv) begin
         mvalid_ff <= in_valid;
         valid_ff  <= mvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mside_ff  <= in_side;
         prod_ff   <= prod_in;
         ang_ff    <= ang_in;
         sum_re_ff <= sum_re_in;
         sum_im_ff <= sum_im_in;
         mag_ff    <= mag_in;
         angle_ff  <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign sum_re    = sum_re_ff;
   assign sum_im    = sum_im_ff;
   assign magnitude = mag_ff;
   assign angle     = angle_ff;

endmodule

/* rtl/complex_add_sub_magnitude_angle_top.sv */
// Complex add/sub, magnitude and angle unit. Takes one request transaction per
// clock cycle while the pipeline is not held, and returns one response per
// request, in order. Every request passes the same pipeline of CORDIC_STAGES + 3
// registers (operand stage, one register per cordic micro-rotation, the gain
// multiplier, the output register).
// When a response waits in the output register and is not taken, the whole
// pipeline holds and req_chan.ready drops in the same cycle; nothing is lost.
// depends on cas_pkg, cas_if, cas_prep, cas_cordic_stage, cas_finish
module complex_add_sub_magnitude_angle_top #(
   parameter int CORDIC_STAGES = cas_pkg::CORDIC_STAGES_DEF
) (
   input logic        clock,
   input logic        reset,
   cas_req_if.sink    req_chan,
   cas_rsp_if.source  rsp_chan
);
   import cas_pkg::*;

   logic     adv;
   logic     st_valid [CORDIC_STAGES+1];
   side_type st_side  [CORDIC_STAGES+1];
   vec_type  st_vec   [CORDIC_STAGES+1];

   // the pipeline moves whenever the output register is free or being emptied
   assign adv            = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   cas_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .in_op     (req_chan.op),
      .a_re      (req_chan.a_re),
      .a_im      (req_chan.a_im),
      .b_re      (req_chan.b_re),
      .b_im      (req_chan.b_im),
      .out_valid (st_valid[0]),
      .out_side  (st_side[0]),
      .out_vec   (st_vec[0])
   );

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      cas_cordic_stage #(
         .STAGE_IDX (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (st_valid[k]),
         .in_side   (st_side[k]),
         .in_vec    (st_vec[k]),
         .out_valid (st_valid[k+1]),
         .out_side  (st_side[k+1]),
         .out_vec   (st_vec[k+1])
      );
   end

   cas_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (st_valid[CORDIC_STAGES]),
      .in_side   (st_side[CORDIC_STAGES]),
      .in_vec    (st_vec[CORDIC_STAGES]),
      .out_valid (rsp_chan.valid),
      .sum_re    (rsp_chan.sum_re),
      .sum_im    (rsp_chan.sum_im),
      .magnitude (rsp_chan.magnitude),
      .angle     (rsp_chan.angle)
   );

endmodule

/* rtl/cas_checker.sv */
// port-level checks of the complex add/sub, magnitude and angle unit
// depends on cas_pkg; bound to complex_add_sub_magnitude_angle_top
module cas_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [cas_pkg::SUM_W-1:0] rsp_sum_re,
   input logic signed [cas_pkg::SUM_W-1:0] rsp_sum_im,
   input logic [cas_pkg::MAG_W-1:0]        rsp_magnitude,
   input logic signed [cas_pkg::ANG_W-1:0] rsp_angle
);
   import cas_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sum_re) && $stable(rsp_sum_im)
         && $stable(rsp_magnitude) && $stable(rsp_angle))
      else $error("response payload changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request stalled with an empty output register");

   // only one kind of result is non-zero in a transaction
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_magnitude == '0 || (rsp_angle == '0 && rsp_sum_re == '0
         && rsp_sum_im == '0)) && (rsp_angle == '0 || (rsp_sum_re == '0
         && rsp_sum_im == '0)))
      else $error("mixed result fields in one response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind complex_add_sub_magnitude_angle_top cas_checker u_cas_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_sum_re    (rsp_chan.sum_re),
   .rsp_sum_im    (rsp_chan.sum_im),
   .rsp_magnitude (rsp_chan.magnitude),
   .rsp_angle     (rsp_chan.angle)
);

/* test/complex_add_sub_magnitude_angle_top_tb.sv */
// testbench for the complex add/sub, magnitude and angle unit: random and directed
// transactions with random gaps on both channels, checked in order against a predictor
// depends on cas_pkg, cas_if and complex_add_sub_magnitude_angle_top
module complex_add_sub_magnitude_angle_top_tb;
   import cas_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CORDIC_STAGES  = 16;
   localparam int LATENCY        = CORDIC_STAGES + 3;
   localparam int RANDOM_ITEMS   = 1730;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_CAP      = 60;

   localparam int  ROT_TABLE_LEN = 24;
   localparam int  SCALE_BITS    = 14;
   localparam longint unsigned GAIN_Q30 = 64'd652032874;
   localparam longint MAG_LIMIT   = 46341;
   localparam longint ANGLE_LIMIT = 12868;

   // atan(2^-i) in units of 2^-30 rad
   localparam longint ROT_ANGLE [ROT_TABLE_LEN] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127
   };

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
   } request_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum_re;
      logic signed [SUM_W-1:0] sum_im;
      logic [MAG_W-1:0]        magnitude;
      logic signed [ANG_W-1:0] angle;
   } response_type;

   class response_scoreboard;
      response_type expected_responses[$];
      int unsigned  errors;
      int unsigned  checked;

      function new();
         errors  = 0;
         checked = 0;
      endfunction

      function void report(string what, longint got, longint want);
         if (errors < PRINT_CAP)
            $display("%0t ns: response %0d %s: got %0d, expected %0d",
                     $time, checked, what, got, want);
         errors++;
      endfunction

      function response_type predict_response(request_type r);
         longint    re, im, x, y, z, xs, ys, q, s_re, s_im;
         longint unsigned mag;
         response_type res;
         res = '0;
         if (r.op == OP_ADD || r.op == OP_SUB) begin
            if (r.op == OP_ADD) begin
               s_re = longint'(r.a_re) + longint'(r.b_re);
               s_im = longint'(r.a_im) + longint'(r.b_im);
            end else begin
               s_re = longint'(r.a_re) - longint'(r.b_re);
               s_im = longint'(r.a_im) - longint'(r.b_im);
            end
            res.sum_re = s_re[SUM_W-1:0];
            res.sum_im = s_im[SUM_W-1:0];
         end else begin
            re = longint'(r.b_re);
            im = longint'(r.b_im);
            // left half plane folds over, atan(im/re) is unchanged
            if (re < 0) begin
               re = -re;
               im = -im;
            end
            x = re * (longint'(1) << SCALE_BITS);
            y = im * (longint'(1) << SCALE_BITS);
            z = 0;
            for (int i = 0; i < CORDIC_STAGES && i < ROT_TABLE_LEN; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y >= 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + ROT_ANGLE[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - ROT_ANGLE[i];
               end
            end
            mag = (longint'(unsigned'(x)) * GAIN_Q30 + (64'd1 << 43)) >> 44;
            if (mag > MAG_LIMIT)
               mag = MAG_LIMIT;
            q = (z + (longint'(1) << 16)) >>> 17;
            if (q > ANGLE_LIMIT)
               q = ANGLE_LIMIT;
            if (q < -ANGLE_LIMIT)
               q = -ANGLE_LIMIT;
            // imaginary axis: angle follows the sign of im alone
            if (r.b_re == 0)
               q = (r.b_im > 0) ? ANGLE_LIMIT : ((r.b_im < 0) ? -ANGLE_LIMIT : 0);
            if (r.op == OP_MAG)
               res.magnitude = mag[MAG_W-1:0];
            else
               res.angle = q[ANG_W-1:0];
         end
         return res;
      endfunction

      function void note_request(request_type r);
         expected_responses.push_back(predict_response(r));
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (expected_responses.size() == 0) begin
            report("arrived with nothing outstanding", 0, 0);
         end else begin
            want = expected_responses.pop_front();
            if (got.sum_re !== want.sum_re)
               report("sum_re", got.sum_re, want.sum_re);
            if (got.sum_im !== want.sum_im)
               report("sum_im", got.sum_im, want.sum_im);
            if (got.magnitude !== want.magnitude)
               report("magnitude", got.magnitude, want.magnitude);
            if (got.angle !== want.angle)
               report("angle", got.angle, want.angle);
         end
         checked++;
      endfunction

      function int outstanding();
         return expected_responses.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;
   int   idle_cycles = 0;

   response_scoreboard scoreboard;

   cas_req_if req_chan ();
   cas_rsp_if rsp_chan ();

   complex_add_sub_magnitude_angle_top #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(3, 0));
   endfunction

   function automatic request_type make_request(op_type op, int ar, int ai, int br, int bi);
      request_type r;
      r.op   = op;
      r.a_re = ar[DATA_W-1:0];
      r.a_im = ai[DATA_W-1:0];
      r.b_re = br[DATA_W-1:0];
      r.b_im = bi[DATA_W-1:0];
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_operand();
      int v;
      case ($urandom_range(7, 0))
         0: begin
            case ($urandom_range(4, 0))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         1, 2: v = int'($urandom_range(512, 0)) - 256;
         default: v = int'($urandom);
      endcase
      return v[DATA_W-1:0];
   endfunction

   function automatic request_type random_request();
      request_type r;
      r.op   = op_type'($urandom_range(3, 0));
      r.a_re = random_operand();
      r.a_im = random_operand();
      r.b_re = random_operand();
      r.b_im = random_operand();
      // lean on the axes; on the imaginary axis the angle takes its special path
      case ($urandom_range(15, 0))
         0: r.b_re = '0;
         1: begin
            r.b_re = '0;
            r.b_im = '0;
         end
         2: r.b_im = '0;
         default: ;
      endcase
      return r;
   endfunction

   // called and returns at a falling edge
   task automatic send_request(request_type r);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.op    <= r.op;
      req_chan.a_re  <= r.a_re;
      req_chan.a_im  <= r.a_im;
      req_chan.b_re  <= r.b_re;
      req_chan.b_im  <= r.b_im;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   task automatic drive_responses();
      int stall;
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   endtask

   task automatic run_directed();
      send_request(make_request(OP_ADD, 32767, 32767, 32767, 32767));
      send_request(make_request(OP_ADD, -32768, -32768, -32768, -32768));
      send_request(make_request(OP_ADD, 21845, -21846, -1, 1));
      send_request(make_request(OP_SUB, -32768, -32768, 32767, 32767));
      send_request(make_request(OP_SUB, 32767, 32767, -32768, -32768));
      send_request(make_request(OP_SUB, 0, 0, -32768, 1));
      send_request(make_request(OP_MAG, 32767, -32768, 32767, 32767));
      send_request(make_request(OP_MAG, -32768, 32767, -32768, -32768));
      send_request(make_request(OP_MAG, 1, 1, 0, 0));
      send_request(make_request(OP_MAG, 0, 0, 0, 100));
      send_request(make_request(OP_MAG, 0, 0, -32768, 0));
      send_request(make_request(OP_MAG, 0, 0, 1, 0));
      send_request(make_request(OP_MAG, 0, 0, -1, -1));
      send_request(make_request(OP_MAG, 0, 0, 0, -32768));
      send_request(make_request(OP_ANGLE, 5, 5, 0, 5));
      send_request(make_request(OP_ANGLE, 0, 0, 0, -5));
      send_request(make_request(OP_ANGLE, -1, -1, 0, 0));
      send_request(make_request(OP_ANGLE, 0, 0, -32768, -32768));
      send_request(make_request(OP_ANGLE, 0, 0, 32767, -32768));
      send_request(make_request(OP_ANGLE, 0, 0, -1, 1));
      send_request(make_request(OP_ANGLE, 0, 0, 100, 0));
      send_request(make_request(OP_ANGLE, 0, 0, -100, 0));
      send_request(make_request(OP_ANGLE, 0, 0, 1, 32767));
      send_request(make_request(OP_ANGLE, 0, 0, -1, -32768));
   endtask

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         scoreboard.note_request(make_request(op_type'(req_chan.op), req_chan.a_re,
                                              req_chan.a_im, req_chan.b_re, req_chan.b_im));
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         scoreboard.check_response(response_type'{rsp_chan.sum_re, rsp_chan.sum_im,
                                                  rsp_chan.magnitude, rsp_chan.angle});
   end

   // ends the run when no transaction moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("complex_add_sub_magnitude_angle_top_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      scoreboard     = new();
      req_chan.valid = 1'b0;
      req_chan.op    = '0;
      req_chan.a_re  = '0;
      req_chan.a_im  = '0;
      req_chan.b_re  = '0;
      req_chan.b_im  = '0;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      fork
         drive_responses();
      join_none
      run_directed();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // some stretches run back to back with no gaps on either side
         if (n % 125 == 0)
            no_idle = ($urandom_range(2, 0) == 0);
         send_request(random_request());
      end
      req_chan.valid <= 1'b0;
      while (scoreboard.outstanding() > 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (scoreboard.errors == 0)
         $display("complex_add_sub_magnitude_angle_top_tb: clean");
      else
         $display("complex_add_sub_magnitude_angle_top_tb: errors");
      $finish;
   end

endmodule

/* files.f */
rtl/cas_pkg.sv
rtl/cas_if.sv
rtl/cas_prep.sv
rtl/cas_cordic_stage.sv
rtl/cas_finish.sv
rtl/complex_add_sub_magnitude_angle_top.sv
rtl/cas_checker.sv
test/complex_add_sub_magnitude_angle_top_tb.sv
